// ===== design/vl2n_pkg.sv =====
// vl2n_pkg: shared constants, types and helpers for the L2 vector normaliser.
// No dependencies; imported by the interfaces and every module.
`timescale 1ns / 1ps

package vl2n_pkg;

  localparam int MAX_LENGTH = 64;
  localparam int SAMPLE_W   = 16;
  localparam int LEN_W      = 7;
  localparam int IDX_W      = $clog2(MAX_LENGTH);
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int SUM_W      = 2 * SAMPLE_W - 1 + IDX_W;
  localparam int DREM_W     = SUM_W + 1;
  localparam int QUO_W      = 31;
  localparam int ROOT_W     = 16;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int SOP_W      = 2 * ROOT_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int CNT_W      = 5;

  localparam logic [LEN_W-1:0] VLEN_RESET = LEN_W'(36);
  localparam logic [LEN_W-1:0] VLEN_MAX   = LEN_W'(MAX_LENGTH);

  typedef enum logic [2:0] {
    S_COLLECT,
    S_SETTLE,
    S_READ,
    S_SQUARE,
    S_DIV,
    S_SQRT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             sq_load;
    logic             div_step;
    logic             sqrt_step;
    logic             first;
    logic             clr_sum;
  } cmd_t;

  typedef struct packed {
    logic sum_zero;
  } status_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (v > VLEN_MAX) begin
      r = VLEN_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] r;
    if (s[SAMPLE_W-1]) begin
      r = ~s + SAMPLE_W'(1);
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// ===== design/vl2n_stream_if.sv =====
// Stream interfaces for sample input and normalised result output.
// Depends on vl2n_pkg for field widths.
`timescale 1ns / 1ps

interface vl2n_sample_if
  import vl2n_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface vl2n_result_if
  import vl2n_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic signed [15:0]  normalized;
  logic [IDX_W-1:0]    element_index;
  logic                last_out;
  logic                zero_vector;

  modport source (output valid, output normalized, output element_index,
                  output last_out, output zero_vector, input ready);
  modport sink   (input valid, input normalized, input element_index,
                  input last_out, input zero_vector, output ready);
endinterface

// ===== design/vector_l2_normalizer_top.sv =====
// vector_l2_normalizer_top: L2 normaliser, controller plus datapath.
// Depends on vl2n_pkg, vl2n_stream_if, vl2n_ctrl, vl2n_datapath.
//
//   port       dir  kind          carries
//   in_ch      in   valid/ready   sample
//   out_ch     out  valid/ready   normalized, element_index, last_out, zero_vector
//   cfg_wr_*   in   write enable  vector_length
//
// In collect, one element per cycle is taken; a settle state follows the last one.
// Each result then runs read, square, 31 divide steps, 16 root steps and present
// on the one divider and root unit shared by all elements; an all-zero vector
// skips divide and root. Input is not taken while a vector is being emitted.
// rst_n is synchronous, active low; the length returns to 36.
// A stalled result holds until out_ch.ready.
`timescale 1ns / 1ps

module vector_l2_normalizer_top
  import vl2n_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  vl2n_sample_if.sink      in_ch,
  vl2n_result_if.source    out_ch
);

  cmd_t    cmd;
  status_t sts;

  vl2n_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_index   (out_ch.element_index),
    .out_last    (out_ch.last_out),
    .cmd         (cmd),
    .sts         (sts)
  );

  vl2n_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_sample      (in_ch.sample),
    .cmd            (cmd),
    .sts            (sts),
    .out_normalized (out_ch.normalized)
  );

  assign out_ch.zero_vector = sts.sum_zero;

endmodule

// ===== design/vl2n_ctrl.sv =====
// vl2n_ctrl: controller FSM - fill count, element pointer, step counter,
// length register. Depends on vl2n_pkg; drives vl2n_datapath via cmd_t.
`timescale 1ns / 1ps

module vl2n_ctrl
  import vl2n_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_index,
  output logic             out_last,
  output cmd_t             cmd,
  input  status_t          sts
);

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] vlen_r, vlen_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] len;
  logic             last_k;

  assign len       = eff_len(vlen_r);
  assign last_k    = ({1'b0, k_r} + LEN_W'(1)) == len;
  assign out_index = k_r;
  assign out_last  = last_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
      vlen_r  <= VLEN_RESET;
      fill_r  <= '0;
      k_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      vlen_r  <= vlen_nxt;
      fill_r  <= fill_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    vlen_nxt    = vlen_r;
    fill_nxt    = fill_r;
    k_nxt       = k_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.wr_addr = fill_r[IDX_W-1:0];
    cmd.rd_addr = k_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;

    unique case (state_r)
      S_COLLECT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_en = 1'b1;
          if (fill_r + LEN_W'(1) == len) begin
            fill_nxt  = '0;
            state_nxt = S_SETTLE;
          end else begin
            fill_nxt = fill_r + LEN_W'(1);
          end
        end
      end
      S_SETTLE: begin
        // last square lands in the sum this cycle
        k_nxt     = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.sq_load = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = sts.sum_zero ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.first    = (cnt_r == '0);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cmd.first     = (cnt_r == '0);
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (last_k) begin
            cmd.clr_sum = 1'b1;
            k_nxt       = '0;
            state_nxt   = S_COLLECT;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase

    // new length drops any partial vector
    if (cfg_wr_en) begin
      vlen_nxt    = cfg_wr_data;
      fill_nxt    = '0;
      cmd.clr_sum = 1'b1;
    end
  end

endmodule

// ===== design/vl2n_datapath.sv =====
// vl2n_datapath: element store, square-sum accumulator, radix-2 restoring
// divider and digit-by-digit square root. Depends on vl2n_pkg; run by vl2n_ctrl.
`timescale 1ns / 1ps

module vl2n_datapath
  import vl2n_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  cmd_t                       cmd,
  output status_t                    sts,
  output logic signed [15:0]         out_normalized
);

  logic [SAMPLE_W-1:0] mem [MAX_LENGTH];
  logic [SAMPLE_W-1:0] rd_data_r;

  logic [SQ_W-1:0]     sqin_r;
  logic                sqin_vld_r;
  logic [SUM_W-1:0]    sum_r;

  logic [SQ_W-1:0]     sq_r;
  logic                sign_r;

  logic [SUM_W-1:0]    drem_r, drem_nxt;
  logic [QUO_W-1:0]    quo_r, quo_nxt;
  logic [DREM_W-1:0]   d_rr, d_diff;
  logic                d_ge;

  logic [SOP_W-1:0]    sop_r, s_src;
  logic [SREM_W-1:0]   srem_r, s_rem_src;
  logic [ROOT_W-1:0]   root_r, s_root_src, root_nxt;
  logic [SREM_W+1:0]   s_rt, s_trial, s_rem;
  logic                s_ge;

  logic [SAMPLE_W-1:0] in_mag, rd_mag;

  assign in_mag = magnitude(in_sample);
  assign rd_mag = magnitude(rd_data_r);

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= in_sample;
    end
    rd_data_r <= mem[cmd.rd_addr];
  end

  // square registered before accumulation
  always_ff @(posedge clk) begin
    sqin_r <= in_mag * in_mag;
    if (!rst_n) begin
      sqin_vld_r <= 1'b0;
      sum_r      <= '0;
    end else begin
      sqin_vld_r <= cmd.wr_en;
      if (cmd.clr_sum) begin
        sum_r <= '0;
      end else if (sqin_vld_r) begin
        sum_r <= sum_r + SUM_W'(sqin_r);
      end
    end
  end

  assign sts.sum_zero = (sum_r == '0);

  always_comb begin
    d_rr     = cmd.first ? DREM_W'(sq_r) : {drem_r, 1'b0};
    d_diff   = d_rr - {1'b0, sum_r};
    d_ge     = d_rr >= {1'b0, sum_r};
    drem_nxt = d_ge ? d_diff[SUM_W-1:0] : d_rr[SUM_W-1:0];
    quo_nxt  = cmd.first ? QUO_W'(d_ge) : {quo_r[QUO_W-2:0], d_ge};
  end

  always_comb begin
    s_src      = cmd.first ? SOP_W'(quo_r) : sop_r;
    s_rem_src  = cmd.first ? '0 : srem_r;
    s_root_src = cmd.first ? '0 : root_r;
    s_rt       = {s_rem_src, s_src[SOP_W-1:SOP_W-2]};
    s_trial    = (SREM_W+2)'({s_root_src, 2'b01});
    s_ge       = s_rt >= s_trial;
    s_rem      = s_ge ? (s_rt - s_trial) : s_rt;
    root_nxt   = {s_root_src[ROOT_W-2:0], s_ge};
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      sq_r   <= rd_mag * rd_mag;
      sign_r <= rd_data_r[SAMPLE_W-1];
    end
    if (cmd.div_step) begin
      drem_r <= drem_nxt;
      quo_r  <= quo_nxt;
    end
    if (cmd.sqrt_step) begin
      sop_r  <= {s_src[SOP_W-3:0], 2'b00};
      srem_r <= s_rem[SREM_W-1:0];
      root_r <= root_nxt;
    end
  end

  always_comb begin
    if (sts.sum_zero) begin
      out_normalized = '0;
    end else if (sign_r) begin
      out_normalized = signed'(16'd0 - root_r);
    end else if (root_r[ROOT_W-1]) begin
      out_normalized = 16'sh7FFF;
    end else begin
      out_normalized = signed'(root_r);
    end
  end

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for vector_l2_normalizer_top, predicting every
// normalised element in Q1.15 and checking each result transfer as it arrives.
// Depends on vl2n_pkg, vl2n_stream_if and the vector_l2_normalizer_top RTL.
`timescale 1ns / 1ps

module testbench;
  import vl2n_pkg::*;

  typedef struct {
    logic signed [15:0] normalized;
    logic [IDX_W-1:0]   element_index;
    logic               last_out;
    logic               zero_vector;
  } norm_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [LEN_W-1:0]     cfg_wr_data;

  vl2n_sample_if in_if ();
  vl2n_result_if out_if ();

  vector_l2_normalizer_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_if),
    .out_ch      (out_if)
  );

  // predictor state
  logic [LEN_W-1:0]           len_reg;
  logic signed [SAMPLE_W-1:0] elem_mem [MAX_LENGTH];
  longint unsigned            sq_acc;
  int                         fill_cnt;
  norm_result_t               norm_queue [$];

  int  mismatches;
  int  items_sent;
  int  results_seen;
  int  lengths_written;
  bit  gaps_on;
  bit  stalls_on;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL vector_l2_normalizer_top");
    $finish;
  end

  function automatic longint unsigned elem_mag(input logic signed [SAMPLE_W-1:0] s);
    longint v;
    v = longint'(s);
    return (v < 0) ? unsigned'(-v) : unsigned'(v);
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= x) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  task automatic absorb_element(input logic signed [SAMPLE_W-1:0] v);
    int              eff;
    int              k;
    longint unsigned m;
    longint unsigned q;
    logic [15:0]     q16;
    norm_result_t    r;
    eff = (len_reg == '0) ? 1 : ((int'(len_reg) > MAX_LENGTH) ? MAX_LENGTH : int'(len_reg));
    if (fill_cnt >= eff) begin
      fill_cnt = 0;
      sq_acc = 0;
    end
    elem_mem[fill_cnt] = v;
    m = elem_mag(v);
    sq_acc += m * m;
    fill_cnt++;
    if (fill_cnt == eff) begin
      for (k = 0; k < eff; k++) begin
        r.zero_vector = (sq_acc == 0);
        r.normalized = '0;
        if (!r.zero_vector) begin
          m = elem_mag(elem_mem[k]);
          q = floor_sqrt(((m * m) << 30) / sq_acc);
          q16 = q[15:0];
          if (elem_mem[k] < 0) r.normalized = -q16;
          else r.normalized = (q > 32767) ? 16'sh7FFF : q16;
        end
        r.element_index = IDX_W'(k);
        r.last_out = (k == eff - 1);
        norm_queue.push_back(r);
      end
      fill_cnt = 0;
      sq_acc = 0;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    norm_result_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (norm_queue.size() == 0) begin
        $error("unexpected result transfer: normalized %0d index %0d",
               out_if.normalized, out_if.element_index);
        mismatches++;
      end else begin
        e = norm_queue.pop_front();
        if (out_if.normalized !== e.normalized) begin
          $error("normalized: expected %0d, got %0d", e.normalized, out_if.normalized);
          mismatches++;
        end
        if (out_if.element_index !== e.element_index) begin
          $error("element_index: expected %0d, got %0d", e.element_index,
                 out_if.element_index);
          mismatches++;
        end
        if (out_if.last_out !== e.last_out) begin
          $error("last_out: expected %0b, got %0b", e.last_out, out_if.last_out);
          mismatches++;
        end
        if (out_if.zero_vector !== e.zero_vector) begin
          $error("zero_vector: expected %0b, got %0b", e.zero_vector, out_if.zero_vector);
          mismatches++;
        end
      end
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (399) @(negedge clk);
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_if.ready = 1'b0;
        n = $urandom_range(1, 17);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.sample = v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    absorb_element(v);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (norm_queue.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] v);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    len_reg = v;
    fill_cnt = 0;
    sq_acc = 0;
    lengths_written++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    logic signed [SAMPLE_W-1:0] s;
    r = $urandom_range(0, 19);
    if (r < 11) s = SAMPLE_W'($urandom);
    else if (r < 16) s = SAMPLE_W'($urandom_range(0, 16)) - SAMPLE_W'(8);
    else if (r == 16) s = 16'sh7FFF;
    else if (r == 17) s = 16'sh8000;
    else if (r == 18) s = -16'sd1;
    else s = '0;
    return s;
  endfunction

  // partial vector at the reset length, discarded by the next length write
  task automatic test_partial_at_reset();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh5555);
  endtask

  task automatic test_single_element();
    write_length(LEN_W'(1));
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(-16'sd1);
  endtask

  task automatic test_length_zero();
    write_length('0);
    send_sample(16'sd7);
    send_sample(-16'sd7);
  endtask

  task automatic test_pairs();
    write_length(LEN_W'(2));
    send_sample(16'sh0000);
    send_sample(16'sh0000);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0001);
    send_sample(16'sh0001);
    send_sample(16'sh8000);
  endtask

  task automatic test_alternating_bits();
    write_length(LEN_W'(3));
    send_sample(16'shAAAA);
    send_sample(16'sh5555);
    send_sample(16'sh0000);
    send_sample(16'sh1234);
    send_sample(-16'sd300);
  endtask

  task automatic test_oversize_lengths();
    logic [LEN_W-1:0] lens [4];
    int i, k;
    lens = '{LEN_W'(127), LEN_W'(64), LEN_W'(65), LEN_W'(36)};
    for (i = 0; i < 4; i++) begin
      write_length(lens[i]);
      for (k = 0; k < MAX_LENGTH && k < int'(lens[i]); k++) send_sample(pick_sample());
    end
  endtask

  task automatic test_random_vectors(input int n_items, input int max_len);
    int start, len, k, cut;
    bit zero_vec;
    start = items_sent;
    while (items_sent - start < n_items) begin
      len = $urandom_range(1, max_len);
      write_length(LEN_W'(len));
      repeat ($urandom_range(1, 4)) begin
        zero_vec = ($urandom_range(0, 9) == 0);
        for (k = 0; k < len; k++) send_sample(zero_vec ? '0 : pick_sample());
      end
      if (len > 1 && $urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, len - 1);
        for (k = 0; k < cut; k++) send_sample(pick_sample());
      end
    end
  endtask

  task automatic test_backpressure();
    int k;
    write_length(LEN_W'(4));
    gaps_on = 1'b0;
    hold_req = 1'b1;
    for (k = 0; k < 12; k++) send_sample(pick_sample());
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    len_reg = VLEN_RESET;
    fill_cnt = 0;
    sq_acc = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    lengths_written = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_req = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_partial_at_reset();
    test_single_element();
    test_length_zero();
    test_pairs();
    test_alternating_bits();
    test_oversize_lengths();
    test_random_vectors(120, 12);
    test_backpressure();
    test_random_vectors(80, 16);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    test_random_vectors(60, 8);

    wait_idle();
    repeat (100) @(negedge clk);
    $display("Sent %0d elements over %0d length settings (0..127), checked %0d results,",
             items_sent, lengths_written, results_seen);
    $display("including zero vectors, saturation, discarded partial vectors and a long stall.");
    if (mismatches == 0) begin
      $display("PASS vector_l2_normalizer_top");
    end else begin
      $display("FAIL vector_l2_normalizer_top");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/vl2n_pkg.sv
design/vl2n_stream_if.sv
design/vl2n_ctrl.sv
design/vl2n_datapath.sv
design/vector_l2_normalizer_top.sv
dv/testbench.sv
